@@ design/msu_pkg.sv @@
// shared types, opcodes and memory sizing for the execute unit
package msu_pkg;

    // data memory geometry (power of two bytes, four byte lanes)
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROW_W     = MEM_AW - 2;
    localparam int ROWS      = MEM_BYTES / 4;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_REGIMM   = 6'h01;
    localparam logic [5:0] OP_J        = 6'h02;
    localparam logic [5:0] OP_JAL      = 6'h03;
    localparam logic [5:0] OP_BEQ      = 6'h04;
    localparam logic [5:0] OP_BNE      = 6'h05;
    localparam logic [5:0] OP_BLEZ     = 6'h06;
    localparam logic [5:0] OP_BGTZ     = 6'h07;
    localparam logic [5:0] OP_ADDI     = 6'h08;
    localparam logic [5:0] OP_SLTI     = 6'h0A;
    localparam logic [5:0] OP_ANDI     = 6'h0C;
    localparam logic [5:0] OP_ORI      = 6'h0D;
    localparam logic [5:0] OP_XORI     = 6'h0E;
    localparam logic [5:0] OP_LUI      = 6'h0F;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
    localparam logic [5:0] OP_LB       = 6'h20;
    localparam logic [5:0] OP_LH       = 6'h21;
    localparam logic [5:0] OP_LW       = 6'h23;
    localparam logic [5:0] OP_SB       = 6'h28;
    localparam logic [5:0] OP_SH       = 6'h29;
    localparam logic [5:0] OP_SW       = 6'h2B;

    // function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_MUL     = 6'h02;

    // regimm branch selectors
    localparam logic [4:0] RT_BLTZ = 5'd0;
    localparam logic [4:0] RT_BGEZ = 5'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SYSCALL = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // access size as byte count minus one
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd3
    } t_size;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        t_status     status;
        logic        is_load;
        logic        is_store;
        t_size       size;
        logic [31:0] ea;
    } t_exec;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] val;
    } t_wb;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [MEM_AW-1:0] addr;
        t_size             size;
        logic [31:0]       wdata;
    } t_mem_req;

endpackage

@@ design/msu_if.sv @@
// handshake channels for instruction beats and result beats
interface msu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface msu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  status;
    logic [31:0] service_code;
    logic [31:0] first_argument;
    logic [31:0] second_argument;

    modport source (output valid, output next_pc, output reg_write, output reg_index,
                    output reg_value, output status, output service_code,
                    output first_argument, output second_argument, input ready);
    modport sink   (input valid, input next_pc, input reg_write, input reg_index,
                    input reg_value, input status, input service_code,
                    input first_argument, input second_argument, output ready);
endinterface

@@ design/mips_subset_execute_unit.sv @@
// top level: operand fetch, execute, load return and result register
//
//  channel  | modport | beat contents
//  i_in     | sink    | instruction
//  o_out    | source  | next_pc, reg_write, reg_index, reg_value, status, syscall args
//
// an instruction beat is taken into the execute stage with its operands read on the
// same edge; non-load instructions pass from execute to the result register and sustain
// one per cycle while o_out is not stalled; loads read the data memory port in the execute
// cycle and pass through the load return stage, blocking the next beat until they leave it
// after reset the data memory is swept to zero, all ROWS (16384) rows, with i_in.ready low
// a stalled o_out holds its beat; execute takes at most one more beat and holds it,
// with i_in.ready low, until the result slot drains
module mips_subset_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msu_in_if.sink       i_in,
    msu_out_if.source    o_out
);
    import msu_pkg::*;

    logic        r_e_valid;
    logic [31:0] r_ins;
    logic [31:0] r_pc;
    logic        r_m_valid;
    logic        r_m_wr;
    logic [4:0]  r_m_idx;
    t_size       r_m_size;
    logic [31:0] r_m_npc;

    logic        r_o_valid;
    logic [31:0] r_o_npc;
    logic        r_o_wr;
    logic [4:0]  r_o_idx;
    logic [31:0] r_o_val;
    t_status     r_o_status;
    logic [31:0] r_o_v0;
    logic [31:0] r_o_a0;
    logic [31:0] r_o_a1;

    logic [31:0] s_val;
    logic [31:0] t_val;
    logic [31:0] v0;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] rdata;
    logic [31:0] ld_val;
    logic        mem_busy;
    logic        out_free;
    logic        e_done;
    logic        e_to_m;
    logic        m_done;
    logic        accept;
    logic        syscall;
    t_exec       ex;
    t_wb         wb;
    t_mem_req    req;

    // stage handshakes
    assign out_free   = !r_o_valid || o_out.ready;
    assign e_done     = r_e_valid && !ex.is_load && out_free;
    assign e_to_m     = r_e_valid && ex.is_load && !r_m_valid;
    assign m_done     = r_m_valid && out_free;
    assign i_in.ready = !mem_busy && (r_m_valid ? m_done : (!r_e_valid || e_done));
    assign accept     = i_in.valid && i_in.ready;

    // register writeback from execute or load return
    always_comb begin
        case (r_m_size)
            SZ_BYTE: ld_val = {{24{rdata[7]}}, rdata[7:0]};
            SZ_HALF: ld_val = {{16{rdata[15]}}, rdata[15:0]};
            default: ld_val = rdata;
        endcase
        wb = '0;
        if (m_done) begin
            wb.en  = r_m_wr;
            wb.idx = r_m_idx;
            wb.val = ld_val;
        end else if (e_done) begin
            wb.en  = ex.wr;
            wb.idx = ex.widx;
            wb.val = ex.wval;
        end
    end

    msu_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_rs    (i_in.instruction[25:21]),
        .i_rt    (i_in.instruction[20:16]),
        .i_wb    (wb),
        .o_s     (s_val),
        .o_t     (t_val),
        .o_v0    (v0),
        .o_a0    (a0),
        .o_a1    (a1)
    );

    msu_exec u_exec (
        .i_ins (r_ins),
        .i_s   (s_val),
        .i_t   (t_val),
        .i_pc  (r_pc),
        .o_ex  (ex)
    );

    // data memory request
    always_comb begin
        req       = '0;
        req.rd    = e_to_m;
        req.wr    = e_done && ex.is_store;
        req.addr  = ex.ea[MEM_AW-1:0];
        req.size  = ex.size;
        req.wdata = t_val;
    end

    msu_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata),
        .o_busy  (mem_busy)
    );

    // execute stage and pc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_pc      <= '0;
        end else begin
            if (e_done || e_to_m) begin
                r_pc <= ex.npc;
            end
            if (accept) begin
                r_e_valid <= 1'b1;
            end else if (e_done || e_to_m) begin
                r_e_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_in.instruction;
        end
    end

    // load return stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (e_to_m) begin
            r_m_valid <= 1'b1;
        end else if (m_done) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_to_m) begin
            r_m_wr   <= ex.wr;
            r_m_idx  <= ex.widx;
            r_m_size <= ex.size;
            r_m_npc  <= ex.npc;
        end
    end

    // result register
    assign syscall = ex.status == ST_SYSCALL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_done || m_done) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_done) begin
            r_o_npc    <= r_m_npc;
            r_o_wr     <= r_m_wr;
            r_o_idx    <= r_m_idx;
            r_o_val    <= r_m_wr ? ld_val : 32'd0;
            r_o_status <= ST_OK;
            r_o_v0     <= 32'd0;
            r_o_a0     <= 32'd0;
            r_o_a1     <= 32'd0;
        end else if (e_done) begin
            r_o_npc    <= ex.npc;
            r_o_wr     <= ex.wr;
            r_o_idx    <= ex.widx;
            r_o_val    <= ex.wval;
            r_o_status <= ex.status;
            r_o_v0     <= syscall ? v0 : 32'd0;
            r_o_a0     <= syscall ? a0 : 32'd0;
            r_o_a1     <= syscall ? a1 : 32'd0;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.next_pc         = r_o_npc;
    assign o_out.reg_write       = r_o_wr;
    assign o_out.reg_index       = r_o_idx;
    assign o_out.reg_value       = r_o_val;
    assign o_out.status          = r_o_status;
    assign o_out.service_code    = r_o_v0;
    assign o_out.first_argument  = r_o_a0;
    assign o_out.second_argument = r_o_a1;

    // execute and load return never hold items at once
    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_e_valid && r_m_valid))
        else $error("execute and load stages both occupied");

    // no beat taken while memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> !i_in.ready)
        else $error("beat accepted during memory clear");

    // register zero is never a writeback target
    a_wb_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb.en |-> wb.idx != 5'd0)
        else $error("writeback to register zero");

    // no beat is taken while a load moves into the return stage
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_to_m |=> !r_e_valid)
        else $error("beat taken while load outstanding");
endmodule

@@ design/msu_regfile.sv @@
// 32-entry register file with registered operand reads and write forwarding
module msu_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [4:0]        i_rs,
    input  logic [4:0]        i_rt,
    input  msu_pkg::t_wb      i_wb,
    output logic [31:0]       o_s,
    output logic [31:0]       o_t,
    output logic [31:0]       o_v0,
    output logic [31:0]       o_a0,
    output logic [31:0]       o_a1
);
    import msu_pkg::*;

    logic [31:0] r_rf [32];
    logic [31:0] r_s;
    logic [31:0] r_t;

    // write port, entry zero is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_rf[k] <= '0;
        end else if (i_wb.en && i_wb.idx != 5'd0) begin
            r_rf[i_wb.idx] <= i_wb.val;
        end
    end

    // operand capture, taking a same-edge write into account
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_s <= (i_wb.en && i_wb.idx == i_rs && i_rs != 5'd0) ? i_wb.val : r_rf[i_rs];
            r_t <= (i_wb.en && i_wb.idx == i_rt && i_rt != 5'd0) ? i_wb.val : r_rf[i_rt];
        end
    end

    assign o_s  = r_s;
    assign o_t  = r_t;
    assign o_v0 = r_rf[2];
    assign o_a0 = r_rf[4];
    assign o_a1 = r_rf[5];
endmodule

@@ design/msu_exec.sv @@
// decode and execute of one instruction word
module msu_exec (
    input  logic [31:0]    i_ins,
    input  logic [31:0]    i_s,
    input  logic [31:0]    i_t,
    input  logic [31:0]    i_pc,
    output msu_pkg::t_exec o_ex
);
    import msu_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] tgt;
    t_exec       ex;

    assign op   = i_ins[31:26];
    assign rt   = i_ins[20:16];
    assign rd   = i_ins[15:11];
    assign sh   = i_ins[10:6];
    assign fn   = i_ins[5:0];
    assign zimm = {16'd0, i_ins[15:0]};
    assign simm = {{16{i_ins[15]}}, i_ins[15:0]};
    assign tgt  = i_pc + {simm[29:0], 2'b00};

    // main decode
    always_comb begin
        ex          = '0;
        ex.npc      = i_pc + 32'd4;
        ex.status   = ST_OK;
        ex.size     = SZ_WORD;
        ex.ea       = i_s + simm;
        case (op)
            OP_SPECIAL: begin
                ex.wr   = 1'b1;
                ex.widx = rd;
                case (fn)
                    FN_ADD:     ex.wval = i_s + i_t;
                    FN_SUB:     ex.wval = i_s - i_t;
                    FN_AND:     ex.wval = i_s & i_t;
                    FN_OR:      ex.wval = i_s | i_t;
                    FN_XOR:     ex.wval = i_s ^ i_t;
                    FN_SLT:     ex.wval = {31'd0, $signed(i_s) < $signed(i_t)};
                    FN_SLLV:    ex.wval = i_t << i_s[4:0];
                    FN_SRLV:    ex.wval = i_t >> i_s[4:0];
                    FN_SLL:     ex.wval = i_t << sh;
                    FN_SRL:     ex.wval = i_t >> sh;
                    FN_JR:      ex.wr = 1'b0;
                    FN_SYSCALL: begin
                        ex.wr     = 1'b0;
                        ex.status = ST_SYSCALL;
                    end
                    default: begin
                        ex.wr     = 1'b0;
                        ex.status = ST_UNKNOWN;
                    end
                endcase
            end
            OP_SPECIAL2: begin
                if (fn == FN_MUL) begin
                    ex.wr   = 1'b1;
                    ex.widx = rd;
                    ex.wval = i_s * i_t;
                end else begin
                    ex.status = ST_UNKNOWN;
                end
            end
            OP_ADDI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = i_s + simm; end
            OP_ANDI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = i_s & zimm; end
            OP_ORI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = i_s | zimm; end
            OP_XORI: begin ex.wr = 1'b1; ex.widx = rt; ex.wval = i_s ^ zimm; end
            OP_SLTI: begin
                ex.wr   = 1'b1;
                ex.widx = rt;
                ex.wval = {31'd0, $signed(i_s) < $signed(simm)};
            end
            OP_LUI:  begin ex.wr = 1'b1; ex.widx = rt; ex.wval = {i_ins[15:0], 16'd0}; end
            OP_LB:   begin ex.wr = 1'b1; ex.widx = rt; ex.is_load = 1'b1; ex.size = SZ_BYTE; end
            OP_LH:   begin ex.wr = 1'b1; ex.widx = rt; ex.is_load = 1'b1; ex.size = SZ_HALF; end
            OP_LW:   begin ex.wr = 1'b1; ex.widx = rt; ex.is_load = 1'b1; ex.size = SZ_WORD; end
            OP_SB:   begin ex.is_store = 1'b1; ex.size = SZ_BYTE; end
            OP_SH:   begin ex.is_store = 1'b1; ex.size = SZ_HALF; end
            OP_SW:   begin ex.is_store = 1'b1; ex.size = SZ_WORD; end
            OP_BEQ:  if (i_s == i_t) ex.npc = tgt;
            OP_BNE:  if (i_s != i_t) ex.npc = tgt;
            OP_BLEZ: if (i_s == 32'd0 || i_s[31]) ex.npc = tgt;
            OP_BGTZ: if (i_s != 32'd0 && !i_s[31]) ex.npc = tgt;
            OP_REGIMM: begin
                if (rt == RT_BLTZ) begin
                    if (i_s[31]) ex.npc = tgt;
                end else if (rt == RT_BGEZ) begin
                    if (!i_s[31]) ex.npc = tgt;
                end else begin
                    ex.status = ST_UNKNOWN;
                end
            end
            OP_J, OP_JAL: ex.wr = 1'b0;
            default: ex.status = ST_UNKNOWN;
        endcase
        // writes to register zero are dropped
        if (!(ex.wr && ex.widx != 5'd0)) begin
            ex.wr   = 1'b0;
            ex.widx = 5'd0;
            ex.wval = 32'd0;
        end
    end

    assign o_ex = ex;
endmodule

@@ design/msu_dmem.sv @@
// byte memory in four lanes with wrapping unaligned access and a clear sweep
module msu_dmem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msu_pkg::t_mem_req    i_req,
    output logic [31:0]          o_rdata,
    output logic                 o_busy
);
    import msu_pkg::*;

    logic [7:0]       r_bank [4][ROWS];
    logic [7:0]       r_q [4];
    logic [1:0]       r_off;
    logic             r_clr;
    logic [ROW_W-1:0] r_clr_row;
    logic [1:0]       off;

    assign off = i_req.addr[1:0];

    // clear sweep, one row of all lanes per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(ROWS - 1)) r_clr <= 1'b0;
        end
    end

    // per lane row, byte slot and write enable
    for (genvar b = 0; b < 4; b++) begin : g_lane
        logic [ROW_W-1:0] row;
        logic [1:0]       slot;
        logic             wen;

        assign row  = i_req.addr[MEM_AW-1:2] + ROW_W'(2'(b) < off);
        assign slot = 2'(b) - off;
        assign wen  = i_req.wr && (slot <= i_req.size);

        always_ff @(posedge i_clk) begin
            if (r_clr) begin
                r_bank[b][r_clr_row] <= 8'd0;
            end else if (wen) begin
                r_bank[b][row] <= i_req.wdata[8*slot +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_req.rd) begin
                r_q[b] <= r_bank[b][row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_off <= off;
        end
    end

    // little-endian reassembly from the lane holding the first byte
    assign o_rdata = {r_q[r_off + 2'd3], r_q[r_off + 2'd2], r_q[r_off + 2'd1], r_q[r_off]};
    assign o_busy  = r_clr;
endmodule
